[hdl/ezvad_pkg.sv]
// shared widths, register indexes and reset values of the voice activity detector
package ezvad_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int THR_W      = 15;
   localparam int MS_W       = 16;
   localparam int CONF_W     = 16;
   localparam int SQ_W       = 31;
   localparam int ROOT_W     = 16;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int CONF_NUM_W = ROOT_W + CONF_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEECH_MS    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SILENCE_MS   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_BARGE_IN_ARM     = CSR_IDX_W'(3);

   localparam logic [THR_W-1:0]  THR_RESET         = THR_W'(328);
   localparam logic [MS_W-1:0]   MIN_SPEECH_RESET  = MS_W'(250);
   localparam logic [MS_W-1:0]   MIN_SILENCE_RESET = MS_W'(500);
   localparam logic [CONF_W-1:0] CONF_MAX          = '1;

   // crossing rate window: 20c > count and 2c < count
   localparam int CROSS_LOW_MUL = 20;

endpackage

[hdl/ezvad_front.sv]
// front end: takes sample words, squares them and accumulates one frame summary
module ezvad_front import ezvad_pkg::*; #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic signed [SAMPLE_W-1:0]                    req_sample,
   input  logic                                          req_frame_last,
   input  logic [TIME_W-1:0]                             req_now_ms,
   output logic                                          push,
   output logic [TIME_W+2*$clog2(MAX_FRAME+1)+SQ_W+$clog2(MAX_FRAME+1)-1:0] frame_word,
   input  logic                                          full
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int SUM_W = SQ_W + CNT_W;

   logic                  a_valid_ff, a_valid_in;
   logic [SQ_W-1:0]       a_sq_ff, a_sq_in;
   logic                  a_neg_ff, a_neg_in;
   logic                  a_last_ff, a_last_in;
   logic [TIME_W-1:0]     a_now_ff, a_now_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      cross_ff, cross_in;
   logic                  prev_neg_ff, prev_neg_in;

   logic [SAMPLE_W-1:0]   mag;
   logic [2*SAMPLE_W-1:0] sq_full;
   logic                  accept;
   logic                  advance;
   logic                  in_range;
   logic                  crossed;
   logic [SUM_W-1:0]      sum_add;
   logic [CNT_W-1:0]      cnt_add;
   logic [CNT_W-1:0]      cross_add;
   logic                  prev_add;

   // a closing word waits here while the queue is full
   assign req_stall = a_valid_ff && a_last_ff && full;
   assign accept    = req_valid && !req_stall;
   assign advance   = a_valid_ff && !(a_last_ff && full);

   assign mag     = req_sample[SAMPLE_W-1] ? SAMPLE_W'(-req_sample) : SAMPLE_W'(req_sample);
   assign sq_full = mag * mag;

   // words past the frame limit add nothing
   assign in_range  = cnt_ff < CNT_W'(MAX_FRAME);
   assign crossed   = (cnt_ff != '0) && (a_neg_ff != prev_neg_ff);
   assign sum_add   = in_range ? sum_ff + SUM_W'(a_sq_ff) : sum_ff;
   assign cnt_add   = in_range ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign cross_add = (in_range && crossed) ? cross_ff + CNT_W'(1) : cross_ff;
   assign prev_add  = in_range ? a_neg_ff : prev_neg_ff;

   assign push       = advance && a_last_ff;
   assign frame_word = {a_now_ff, cross_add, cnt_add, sum_add};

   always_comb begin
      a_valid_in  = a_valid_ff;
      a_sq_in     = a_sq_ff;
      a_neg_in    = a_neg_ff;
      a_last_in   = a_last_ff;
      a_now_in    = a_now_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      cross_in    = cross_ff;
      prev_neg_in = prev_neg_ff;
      if (advance) begin
         a_valid_in = 1'b0;
         if (a_last_ff) begin
            sum_in      = '0;
            cnt_in      = '0;
            cross_in    = '0;
            prev_neg_in = 1'b0;
         end else begin
            sum_in      = sum_add;
            cnt_in      = cnt_add;
            cross_in    = cross_add;
            prev_neg_in = prev_add;
         end
      end
      if (accept) begin
         a_valid_in = 1'b1;
         a_sq_in    = sq_full[SQ_W-1:0];
         a_neg_in   = req_sample[SAMPLE_W-1];
         a_last_in  = req_frame_last;
         a_now_in   = req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         cross_ff    <= '0;
         prev_neg_ff <= 1'b0;
      end else begin
         a_valid_ff  <= a_valid_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
         cross_ff    <= cross_in;
         prev_neg_ff <= prev_neg_in;
      end
      a_sq_ff   <= a_sq_in;
      a_neg_ff  <= a_neg_in;
      a_last_ff <= a_last_in;
      a_now_ff  <= a_now_in;
   end

endmodule

[hdl/ezvad_fifo.sv]
// short register queue of frame summaries between front and back
module ezvad_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [WIDTH-1:0]  mem_in [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full     = fill_ff == FILL_W'(DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = push_data;
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      mem_ff <= mem_in;
   end

endmodule

[hdl/ezvad_div.sv]
// restoring divider, one quotient bit per cycle, shared by both frame-end divisions
module ezvad_div #(
   parameter int DD_W = 44,
   parameter int DV_W = 15
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DD_W-1:0] dividend,
   input  logic [DV_W-1:0] divisor,
   output logic            done,
   output logic [DD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DV_W-1:0]   rem_ff, rem_in;
   logic [DD_W-1:0]   quo_ff, quo_in;
   logic [DV_W-1:0]   dvs_ff, dvs_in;

   logic [DV_W:0]     trial;
   logic [DV_W:0]     diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DD_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
         quo_in = {quo_ff[DD_W-2:0], ge};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

endmodule

[hdl/ezvad_back.sv]
// back end: frame decision, confidence, speech tracking, barge-in and result register
module ezvad_back import ezvad_pkg::*; #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  q_pop,
   input  logic [TIME_W+2*$clog2(MAX_FRAME+1)+SQ_W+$clog2(MAX_FRAME+1)-1:0] q_data,
   input  logic                  q_empty,
   output logic                  div_start,
   output logic [((SQ_W+$clog2(MAX_FRAME+1)) > CONF_NUM_W ?
                  (SQ_W+$clog2(MAX_FRAME+1)) : CONF_NUM_W)-1:0] div_dividend,
   output logic [(($clog2(MAX_FRAME+1)) > THR_W ?
                  $clog2(MAX_FRAME+1) : THR_W)-1:0] div_divisor,
   input  logic                  div_done,
   input  logic [((SQ_W+$clog2(MAX_FRAME+1)) > CONF_NUM_W ?
                  (SQ_W+$clog2(MAX_FRAME+1)) : CONF_NUM_W)-1:0] div_quotient,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_frame_is_speech,
   output logic                  rsp_speech_started,
   output logic                  rsp_speech_ended,
   output logic                  rsp_speech_on,
   output logic                  rsp_barge_in,
   output logic [CONF_W-1:0]     rsp_confidence,
   output logic [TIME_W-1:0]     rsp_speech_ms
);

   localparam int CNT_W    = $clog2(MAX_FRAME + 1);
   localparam int SUM_W    = SQ_W + CNT_W;
   localparam int DD_W     = (SUM_W > CONF_NUM_W) ? SUM_W : CONF_NUM_W;
   localparam int DV_W     = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int LIM_W    = 2 * THR_W + CNT_W;
   localparam int X20_W    = CNT_W + 5;
   localparam int ITER_W   = $clog2(ROOT_W);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL1   = 8'b0000_0010,
      ST_MUL2   = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_DIV1   = 8'b0001_0000,
      ST_SQRT   = 8'b0010_0000,
      ST_DIV2   = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } back_state_type;

   back_state_type      state_ff, state_in;

   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [MS_W-1:0]     min_speech_ff, min_speech_in;
   logic [MS_W-1:0]     min_silence_ff, min_silence_in;
   logic                armed_ff, armed_in;
   logic                active_ff, active_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [TIME_W-1:0]   last_ff, last_in;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cross_ff, cross_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [SUM_W-1:0]    prod_ff, prod_in;
   logic                speech_ff, speech_in;
   logic [CONF_W-1:0]   conf_ff, conf_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                speech_o_ff, speech_o_in;
   logic                started_ff, started_in;
   logic                ended_ff, ended_in;
   logic                on_ff, on_in;
   logic                barge_ff, barge_in_nx;
   logic [CONF_W-1:0]   conf_o_ff, conf_o_in;
   logic [TIME_W-1:0]   dur_ff, dur_in;

   logic [2*THR_W-1:0]  thr_sq;
   logic [LIM_W-1:0]    lim_full;
   logic [X20_W-1:0]    cross20;
   logic [CNT_W:0]      cross2;
   logic                speech_now;
   logic [REM_W+1:0]    sq_trial;
   logic [REM_W+1:0]    sq_sub;
   logic                sq_ge;
   logic [REM_W-1:0]    sq_rem_nx;
   logic [ROOT_W-1:0]   sq_root_nx;
   logic [CONF_NUM_W-1:0] conf_num;
   logic                sqrt_last;
   logic                out_free;
   logic [TIME_W-1:0]   start_eff;
   logic [TIME_W-1:0]   speech_dur;
   logic [TIME_W-1:0]   silence_dur;
   logic                fire;

   assign thr_sq   = thr_ff * thr_ff;
   assign lim_full = prod_ff[2*THR_W-1:0] * cnt_ff;
   assign cross20  = X20_W'(cross_ff) * X20_W'(CROSS_LOW_MUL);
   assign cross2   = {cross_ff, 1'b0};

   assign speech_now = (sum_ff > prod_ff)
                    && (cross20 > X20_W'(cnt_ff))
                    && (cross2 < (CNT_W + 1)'(cnt_ff));

   // one root bit per cycle, two radicand bits shifted in each step
   assign sq_trial   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_sub     = (REM_W + 2)'({root_ff, 2'b01});
   assign sq_ge      = sq_trial >= sq_sub;
   assign sq_rem_nx  = sq_ge ? REM_W'(sq_trial - sq_sub) : REM_W'(sq_trial);
   assign sq_root_nx = {root_ff[ROOT_W-2:0], sq_ge};
   assign sqrt_last  = iter_ff == ITER_W'(ROOT_W - 1);

   // 65535 * root
   assign conf_num = {sq_root_nx, CONF_W'(0)} - CONF_NUM_W'(sq_root_nx);

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign div_start = ((state_ff == ST_DECIDE) && speech_now && (thr_ff != '0))
                   || ((state_ff == ST_SQRT) && sqrt_last);
   assign div_dividend = (state_ff == ST_SQRT) ? DD_W'(conf_num) : DD_W'(sum_ff);
   assign div_divisor  = (state_ff == ST_SQRT) ? DV_W'(thr_ff) : DV_W'(cnt_ff);

   // a fresh start means the duration counts from this frame
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign start_eff   = active_ff ? start_ff : now_ff;
   assign speech_dur  = now_ff - start_eff;
   assign silence_dur = now_ff - last_ff;
   assign fire        = speech_ff && armed_ff && (speech_dur >= TIME_W'(min_speech_ff));

   always_comb begin
      state_in       = state_ff;
      thr_in         = thr_ff;
      min_speech_in  = min_speech_ff;
      min_silence_in = min_silence_ff;
      armed_in       = armed_ff;
      active_in      = active_ff;
      start_in       = start_ff;
      last_in        = last_ff;
      sum_in         = sum_ff;
      cnt_in         = cnt_ff;
      cross_in       = cross_ff;
      now_in         = now_ff;
      prod_in        = prod_ff;
      speech_in      = speech_ff;
      conf_in        = conf_ff;
      rad_in         = rad_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;
      iter_in        = iter_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      speech_o_in    = speech_o_ff;
      started_in     = started_ff;
      ended_in       = ended_ff;
      on_in          = on_ff;
      barge_in_nx    = barge_ff;
      conf_o_in      = conf_o_ff;
      dur_in         = dur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               {now_in, cross_in, cnt_in, sum_in} = q_data;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            prod_in  = SUM_W'(thr_sq);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = SUM_W'(lim_full);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            speech_in = speech_now;
            conf_in   = (speech_now && thr_ff == '0) ? CONF_MAX : '0;
            state_in  = div_start ? ST_DIV1 : ST_OUT;
         end
         ST_DIV1: begin
            if (div_done) begin
               rad_in   = div_quotient[RAD_W-1:0];
               rem_in   = '0;
               root_in  = '0;
               iter_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            rem_in  = sq_rem_nx;
            root_in = sq_root_nx;
            iter_in = iter_ff + ITER_W'(1);
            if (sqrt_last) begin
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               conf_in  = (div_quotient[DD_W-1:CONF_W] != '0) ? CONF_MAX
                                                              : div_quotient[CONF_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               started_in  = 1'b0;
               ended_in    = 1'b0;
               if (speech_ff) begin
                  started_in = !active_ff;
                  active_in  = 1'b1;
                  start_in   = start_eff;
                  last_in    = now_ff;
                  if (fire) begin
                     armed_in = 1'b0;
                  end
               end else if (active_ff && silence_dur >= TIME_W'(min_silence_ff)) begin
                  active_in = 1'b0;
                  ended_in  = 1'b1;
               end
               rsp_valid_in = 1'b1;
               speech_o_in  = speech_ff;
               on_in        = speech_ff ? 1'b1 : active_in;
               barge_in_nx  = fire;
               conf_o_in    = conf_ff;
               dur_in       = fire ? speech_dur : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         unique case (csr_index)
            CSR_ENERGY_THRESHOLD: thr_in         = csr_data[THR_W-1:0];
            CSR_MIN_SPEECH_MS:    min_speech_in  = csr_data[MS_W-1:0];
            CSR_MIN_SILENCE_MS:   min_silence_in = csr_data[MS_W-1:0];
            CSR_BARGE_IN_ARM:     armed_in       = csr_data[0];
            default:              thr_in         = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         thr_ff         <= THR_RESET;
         min_speech_ff  <= MIN_SPEECH_RESET;
         min_silence_ff <= MIN_SILENCE_RESET;
         armed_ff       <= 1'b0;
         active_ff      <= 1'b0;
         start_ff       <= '0;
         last_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         thr_ff         <= thr_in;
         min_speech_ff  <= min_speech_in;
         min_silence_ff <= min_silence_in;
         armed_ff       <= armed_in;
         active_ff      <= active_in;
         start_ff       <= start_in;
         last_ff        <= last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      cross_ff    <= cross_in;
      now_ff      <= now_in;
      prod_ff     <= prod_in;
      speech_ff   <= speech_in;
      conf_ff     <= conf_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      iter_ff     <= iter_in;
      speech_o_ff <= speech_o_in;
      started_ff  <= started_in;
      ended_ff    <= ended_in;
      on_ff       <= on_in;
      barge_ff    <= barge_in_nx;
      conf_o_ff   <= conf_o_in;
      dur_ff      <= dur_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_is_speech = speech_o_ff;
   assign rsp_speech_started  = started_ff;
   assign rsp_speech_ended    = ended_ff;
   assign rsp_speech_on       = on_ff;
   assign rsp_barge_in        = barge_ff;
   assign rsp_confidence      = conf_o_ff;
   assign rsp_speech_ms       = dur_ff;

endmodule

[hdl/energy_zcr_voice_activity_detector.sv]
// top level: energy and zero-crossing voice activity detector
// samples are taken one word per cycle; a closing word waits while the frame queue is full
// a non-speech frame passes the front register and the queue, then back end states MUL1,
// MUL2, DECIDE and OUT; a speech frame with a nonzero threshold also runs DIV1, SQRT and
// DIV2, on the shared one-bit-per-cycle divider (used twice) and the 16-step root
// synchronous reset empties the queue, clears frame sums and speech state, reloads defaults
module energy_zcr_voice_activity_detector import ezvad_pkg::*; #(
   parameter int MAX_FRAME   = 4096,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_frame_last,
   input  logic [TIME_W-1:0]           req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_frame_is_speech,
   output logic                        rsp_speech_started,
   output logic                        rsp_speech_ended,
   output logic                        rsp_speech_on,
   output logic                        rsp_barge_in,
   output logic [CONF_W-1:0]           rsp_confidence,
   output logic [TIME_W-1:0]           rsp_speech_ms,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   localparam int CNT_W   = $clog2(MAX_FRAME + 1);
   localparam int SUM_W   = SQ_W + CNT_W;
   localparam int FRAME_W = TIME_W + 2 * CNT_W + SUM_W;
   localparam int DD_W    = (SUM_W > CONF_NUM_W) ? SUM_W : CONF_NUM_W;
   localparam int DV_W    = (CNT_W > THR_W) ? CNT_W : THR_W;

   logic               fifo_push;
   logic [FRAME_W-1:0] fifo_wdata;
   logic               fifo_full;
   logic               fifo_pop;
   logic [FRAME_W-1:0] fifo_rdata;
   logic               fifo_empty;
   logic               div_start;
   logic [DD_W-1:0]    div_dividend;
   logic [DV_W-1:0]    div_divisor;
   logic               div_done;
   logic [DD_W-1:0]    div_quotient;

   ezvad_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_frame_last (req_frame_last),
      .req_now_ms     (req_now_ms),
      .push           (fifo_push),
      .frame_word     (fifo_wdata),
      .full           (fifo_full)
   );

   ezvad_fifo #(
      .WIDTH (FRAME_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wdata),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_rdata),
      .empty     (fifo_empty)
   );

   ezvad_div #(
      .DD_W (DD_W),
      .DV_W (DV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ezvad_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .q_pop               (fifo_pop),
      .q_data              (fifo_rdata),
      .q_empty             (fifo_empty),
      .div_start           (div_start),
      .div_dividend        (div_dividend),
      .div_divisor         (div_divisor),
      .div_done            (div_done),
      .div_quotient        (div_quotient),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_is_speech (rsp_frame_is_speech),
      .rsp_speech_started  (rsp_speech_started),
      .rsp_speech_ended    (rsp_speech_ended),
      .rsp_speech_on       (rsp_speech_on),
      .rsp_barge_in        (rsp_barge_in),
      .rsp_confidence      (rsp_confidence),
      .rsp_speech_ms       (rsp_speech_ms)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full)
      else $error("frame summary pushed into a full queue");

   a_start_is_speech: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_speech_started) |-> (rsp_frame_is_speech && rsp_speech_on))
      else $error("speech start on a frame that is not speech");

   a_end_is_silence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_speech_ended) |-> (!rsp_frame_is_speech && !rsp_speech_on))
      else $error("speech end with speech still on");

   a_conf_zero_silence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_is_speech) |-> (rsp_confidence == '0 && !rsp_barge_in))
      else $error("confidence or barge-in on a non-speech frame");

endmodule

[bench/ezvad_checker.sv]
// frame decision predictor and result comparator for the voice activity detector bench
module ezvad_checker import ezvad_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_frame_last,
   input  logic [TIME_W-1:0]          req_now_ms,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_frame_is_speech,
   input  logic                       rsp_speech_started,
   input  logic                       rsp_speech_ended,
   input  logic                       rsp_speech_on,
   input  logic                       rsp_barge_in,
   input  logic [CONF_W-1:0]          rsp_confidence,
   input  logic [TIME_W-1:0]          rsp_speech_ms,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT = 4096;

   typedef struct packed {
      logic              voiced;
      logic              started;
      logic              ended;
      logic              on;
      logic              barge;
      logic [CONF_W-1:0] conf;
      logic [TIME_W-1:0] dur;
   } decision_type;

   decision_type      decisions_due[$];
   logic [THR_W-1:0]  thr;
   logic [MS_W-1:0]   need_speech_ms;
   logic [MS_W-1:0]   need_silence_ms;
   longint unsigned   energy_acc;
   int unsigned       crossings;
   int unsigned       frame_len;
   bit                prev_neg;
   bit                talking;
   bit                primed;
   logic [TIME_W-1:0] onset_ms;
   logic [TIME_W-1:0] last_voice_ms;
   int                mismatches = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      // mean square is below 2^31, so the root fits in 16 bits
      for (int b = 20; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic decision_type close_frame(logic [TIME_W-1:0] now);
      decision_type      d;
      longint unsigned   floor_e;
      longint unsigned   scaled;
      logic [TIME_W-1:0] gap;
      d = '0;
      floor_e = 64'(thr) * 64'(thr) * 64'(frame_len);
      d.voiced = (energy_acc > floor_e) && (CROSS_LOW_MUL * crossings > frame_len)
                 && (2 * crossings < frame_len);
      if (d.voiced) begin
         if (thr == 0) begin
            d.conf = CONF_MAX;
         end else begin
            scaled = 64'd65535 * floor_root(energy_acc / frame_len) / thr;
            d.conf = (scaled > 64'd65535) ? CONF_MAX : CONF_W'(scaled);
         end
         if (!talking) begin
            talking = 1'b1;
            onset_ms = now;
            d.started = 1'b1;
         end
         last_voice_ms = now;
         gap = now - onset_ms;
         if (primed && gap >= need_speech_ms) begin
            d.barge = 1'b1;
            d.dur = gap;
            primed = 1'b0;
         end
      end else if (talking) begin
         gap = now - last_voice_ms;
         if (gap >= need_silence_ms) begin
            talking = 1'b0;
            d.ended = 1'b1;
         end
      end
      d.on = talking;
      energy_acc = 0;
      crossings = 0;
      frame_len = 0;
      prev_neg = 1'b0;
      return d;
   endfunction

   task automatic report(input string what, input decision_type want, input decision_type got);
      if (mismatches < 10)
         $display("%0t %s: expected speech=%0b start=%0b end=%0b on=%0b barge=%0b conf=%0d ms=%0d",
                  $realtime, what, want.voiced, want.started, want.ended, want.on,
                  want.barge, want.conf, want.dur,
                  "\n   got speech=%0b start=%0b end=%0b on=%0b barge=%0b conf=%0d ms=%0d",
                  got.voiced, got.started, got.ended, got.on, got.barge, got.conf, got.dur);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      decision_type got;
      decision_type want;
      int           s;
      if (reset) begin
         thr = THR_RESET;
         need_speech_ms = MIN_SPEECH_RESET;
         need_silence_ms = MIN_SILENCE_RESET;
         energy_acc = 0;
         crossings = 0;
         frame_len = 0;
         prev_neg = 1'b0;
         talking = 1'b0;
         primed = 1'b0;
         onset_ms = '0;
         last_voice_ms = '0;
         decisions_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ENERGY_THRESHOLD: thr = csr_data[THR_W-1:0];
               CSR_MIN_SPEECH_MS:    need_speech_ms = csr_data[MS_W-1:0];
               CSR_MIN_SILENCE_MS:   need_silence_ms = csr_data[MS_W-1:0];
               CSR_BARGE_IN_ARM:     primed = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            s = req_sample;
            // words past the frame limit add nothing, but a closing word still decides
            if (frame_len < FRAME_LIMIT) begin
               energy_acc += longint'(s * s);
               if (frame_len != 0 && req_sample[SAMPLE_W-1] != prev_neg) crossings++;
               prev_neg = req_sample[SAMPLE_W-1];
               frame_len++;
            end
            if (req_frame_last) decisions_due.push_back(close_frame(req_now_ms));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_frame_is_speech, rsp_speech_started, rsp_speech_ended, rsp_speech_on,
                   rsp_barge_in, rsp_confidence, rsp_speech_ms};
            if (decisions_due.size() == 0) begin
               report("result with nothing outstanding", '0, got);
            end else begin
               want = decisions_due.pop_front();
               if (got !== want) report("result mismatch", want, got);
            end
         end
      end
      pending <= decisions_due.size();
      fail_count <= mismatches;
   end

endmodule

[bench/tb_energy_zcr_voice_activity_detector.sv]
// top of the voice activity detector bench: clock, reset, stimulus, flow control and verdict
module tb_energy_zcr_voice_activity_detector import ezvad_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 6;
   localparam int SETTLE_CYCLES  = 130;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_FRAME     = 60;

   typedef enum int {FR_QUIET, FR_VOICED, FR_BORDER, FR_NOISE} frame_kind_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_frame_last;
   logic [TIME_W-1:0]          req_now_ms;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_frame_is_speech;
   logic                       rsp_speech_started;
   logic                       rsp_speech_ended;
   logic                       rsp_speech_on;
   logic                       rsp_barge_in;
   logic [CONF_W-1:0]          rsp_confidence;
   logic [TIME_W-1:0]          rsp_speech_ms;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   int                fail_count;
   int                pending;
   int                idle_cycles = 0;
   bit                gaps_on;
   bit                stalls_on;
   bit                hold_req;
   int unsigned       cur_thr;
   logic [TIME_W-1:0] stamp_ms;
   int                pattern[$];

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   energy_zcr_voice_activity_detector DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_frame_last      (req_frame_last),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_is_speech (rsp_frame_is_speech),
      .rsp_speech_started  (rsp_speech_started),
      .rsp_speech_ended    (rsp_speech_ended),
      .rsp_speech_on       (rsp_speech_on),
      .rsp_barge_in        (rsp_barge_in),
      .rsp_confidence      (rsp_confidence),
      .rsp_speech_ms       (rsp_speech_ms),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   ezvad_checker u_vad_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_frame_last      (req_frame_last),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_is_speech (rsp_frame_is_speech),
      .rsp_speech_started  (rsp_speech_started),
      .rsp_speech_ended    (rsp_speech_ended),
      .rsp_speech_on       (rsp_speech_on),
      .rsp_barge_in        (rsp_barge_in),
      .rsp_confidence      (rsp_confidence),
      .rsp_speech_ms       (rsp_speech_ms),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stall bursts, and one long hold when asked for
   initial begin : receiver
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last,
                            input logic [TIME_W-1:0] now);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_frame_last <= last;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_pattern(input logic [TIME_W-1:0] stamp);
      int n;
      n = pattern.size();
      for (int i = 0; i < n; i++)
         send_word(SAMPLE_W'(pattern[i]), i == n - 1, (i == n - 1) ? stamp : $urandom);
   endtask

   task automatic send_frame(input int len, input frame_kind_type kind,
                             input logic [TIME_W-1:0] stamp);
      bit neg;
      int mag;
      int hi;
      int s;
      neg = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
         if (kind == FR_NOISE) begin
            s = int'($signed(SAMPLE_W'($urandom)));
         end else begin
            case (kind)
               FR_QUIET: begin
                  neg = $urandom_range(0, 1);
                  mag = $urandom_range(0, cur_thr / 2);
               end
               FR_VOICED: begin
                  // a sign change on about a quarter of the words keeps the crossing rate in range
                  if ($urandom_range(0, 3) == 0) neg = !neg;
                  mag = $urandom_range(cur_thr, 32767);
               end
               default: begin
                  if ($urandom_range(0, 2) == 0) neg = !neg;
                  hi = (cur_thr * 2 > 32767) ? 32767 : cur_thr * 2;
                  mag = $urandom_range(cur_thr / 2, hi);
               end
            endcase
            s = neg ? -mag : mag;
            if (neg && mag == 32767 && $urandom_range(0, 1) == 1) s = -32768;
         end
         send_word(SAMPLE_W'(s), i == len - 1, (i == len - 1) ? stamp : $urandom);
      end
   endtask

   // block is idle here: every decision is back and the front end has drained
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] thr_d, input logic [CSR_DATA_W-1:0] spd,
                                input logic [CSR_DATA_W-1:0] sil, input logic [CSR_DATA_W-1:0] arm_d);
      csr_write <= 1'b1;
      csr_index <= CSR_ENERGY_THRESHOLD;
      csr_data <= thr_d;
      @(posedge clock);
      csr_index <= CSR_MIN_SPEECH_MS;
      csr_data <= spd;
      @(posedge clock);
      csr_index <= CSR_MIN_SILENCE_MS;
      csr_data <= sil;
      @(posedge clock);
      csr_index <= CSR_BARGE_IN_ARM;
      csr_data <= arm_d;
      @(posedge clock);
      csr_write <= 1'b0;
      cur_thr = thr_d[THR_W-1:0];
   endtask

   task automatic run_phase(input int n_items, input bit gaps, input bit stalls, input bit squeeze);
      int             sent;
      int             len;
      int             pick;
      frame_kind_type kind;
      bit             squeezed;
      gaps_on = gaps;
      stalls_on = stalls;
      sent = 0;
      squeezed = 1'b0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
         pick = $urandom_range(0, 19);
         kind = (pick < 9) ? FR_VOICED : (pick < 15) ? FR_QUIET : (pick < 18) ? FR_BORDER : FR_NOISE;
         pick = $urandom_range(0, 39);
         stamp_ms += (pick == 0) ? $urandom
                   : (pick < 6) ? $urandom_range(100, 900) : $urandom_range(0, 60);
         if (squeeze && !squeezed && sent > n_items / 3) begin
            hold_req = 1'b1;
            squeezed = 1'b1;
         end
         send_frame(len, kind, stamp_ms);
         sent += len;
      end
      settle();
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      req_frame_last <= 1'b0;
      req_now_ms <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_ENERGY_THRESHOLD;
      csr_data <= '0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_req = 1'b0;
      cur_thr = THR_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: single-word frame, loud extremes, short and long silence
      pattern = '{32767};
      send_pattern(32'd1000);
      pattern = '{-32768, 32767, 32767, 32767, -32768, -32768, -32768, -32768};
      send_pattern(32'd1010);
      pattern = '{0, 0, 0, 0};
      send_pattern(32'd1210);
      pattern = '{5, -5, 5, -5, 5, -5};
      send_pattern(32'd1510);
      settle();

      // zero threshold and zero times: barge-in right at speech start, end at once
      apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0001);
      pattern = '{1, -1, 1, 1, 1, 1};
      send_pattern(32'h8000_0000);
      pattern = '{0, 0, 0, 0, 0};
      send_pattern(32'h8000_0000);
      settle();

      // largest settings, with timestamps wrapping past 2^32
      apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
      pattern = '{-32768, -32768, 32767, -32768, -32768, -32768};
      send_pattern(32'hFFFF_FFF0);
      send_pattern(32'h0000_FFF0);
      pattern = '{0, 0, 0};
      send_pattern(32'h0001_FFEE);
      send_pattern(32'h0001_FFEF);
      settle();

      // a longer voiced frame under gaps and stalls, then a short one to show the sums restart
      apply_setting(16'd200, 16'd100, 16'd300, 16'hFFFE);
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      send_frame(LONG_FRAME, FR_VOICED, 32'd5000);
      send_frame(6, FR_VOICED, 32'd5010);
      settle();

      stamp_ms = $urandom;
      apply_setting(16'($urandom_range(50, 3000)), 16'($urandom_range(0, 400)),
                    16'($urandom_range(0, 800)), 16'h0001);
      run_phase(260, 1'b1, 1'b1, 1'b1);
      apply_setting(16'd1, 16'd0, 16'hFFFF, 16'h0001);
      run_phase(240, 1'b1, 1'b0, 1'b0);
      apply_setting(16'd30000, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 16'h0001);
      run_phase(200, 1'b0, 1'b1, 1'b0);
      stamp_ms = 32'hFFFF_F000;
      apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom) | 16'h0001);
      run_phase(260, 1'b1, 1'b1, 1'b0);
      apply_setting(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 400)),
                    16'($urandom_range(0, 800)), 16'h0001);
      run_phase(260, 1'b1, 1'b1, 1'b1);
      // closing stretch runs flat out on both sides
      apply_setting(16'($urandom_range(100, 2000)), 16'($urandom_range(0, 300)), 16'd0, 16'h0001);
      run_phase(300, 1'b0, 1'b0, 1'b0);

      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
